// ----- design/ssrt_pkg.sv -----
`default_nettype none

package ssrt_pkg;

	localparam int FUNC_W  = 2;
	localparam int KEY_W   = 32;
	localparam int SLOT_W  = 9;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	// slot code for "no slot assigned"
	localparam logic [SLOT_W-1:0] SLOT_NONE = '1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_DELETE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_SERVE  = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_DUP       = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ----- design/ssrt_ram.sv -----
`default_nettype none

module ssrt_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/sorted_seq_reorder_table.sv -----
// sorted_seq_reorder_table: reorder table of up to DEPTH entries held in
// ascending sequence order, each entry a sequence number and a signed slot.
// Input channel (in_valid/in_ready) takes one operation per beat: func
// selects insert, delete, lookup or serve-first-unassigned, with key_seq
// and slot_value as operands. Output channel (out_valid/out_ready) returns
// exactly one result beat per operation: status, out_seq, out_slot and the
// entry count after the operation.
// Entries live in a single-port-read RAM and one comparator walks them one
// entry at a time: address in S_RD, then compare on registered read data
// in S_CMP. Insert and delete then move the tail one entry at a time, read
// in S_SH_RD and write in S_SH_WR. in_ready is high only while no operation
// is in progress.
// A finished result sits in the output register; the next operation may be
// accepted while it waits, and is held at its end until the receiver takes
// the earlier beat. Reset empties the table at once; no clearing pass.
module sorted_seq_reorder_table #(
	parameter int DEPTH    = 16,
	parameter int SEQ_BITS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ssrt_pkg::FUNC_W-1:0]     func,
	input  wire logic [ssrt_pkg::KEY_W-1:0]      key_seq,
	input  wire logic [ssrt_pkg::SLOT_W-1:0]     slot_value,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ssrt_pkg::STAT_W-1:0]          status,
	output logic [ssrt_pkg::KEY_W-1:0]           out_seq,
	output logic [ssrt_pkg::SLOT_W-1:0]          out_slot,
	output logic [ssrt_pkg::COUNT_W-1:0]         count_now
);

	import ssrt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (SEQ_BITS < KEY_W) ? SEQ_BITS : KEY_W;
	localparam int EW = SEQ_BITS + SLOT_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_DECIDE,
		S_SH_RD,
		S_SH_WR,
		S_PUT,
		S_RESP
	} state_t;

	state_t                state_q;
	func_t                 func_q;
	logic [SEQ_BITS-1:0]   key_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         pos_q;
	logic [CW-1:0]         count_q;
	logic                  match_q;
	logic [SEQ_BITS-1:0]   seq_hit_q;
	logic [SLOT_W-1:0]     slot_hit_q;
	status_t               res_status_q;
	logic [KEY_W-1:0]      res_seq_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [KEY_W-1:0]      out_seq_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [COUNT_W-1:0]    count_now_q;

	logic [SEQ_BITS-1:0]   key_ext;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [EW-1:0]         ram_wdata;
	logic [EW-1:0]         ram_rdata;
	logic [SEQ_BITS-1:0]   seq_rd;
	logic [SLOT_W-1:0]     slot_rd;
	logic                  seq_eq;
	logic                  seq_ge;
	logic                  hit;
	logic [SEQ_BITS-1:0]   put_seq;

	assign key_ext = SEQ_BITS'(key_seq[KW-1:0]);

	// entry store: {seq, slot} per position
	ssrt_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign seq_rd  = ram_rdata[SLOT_W +: SEQ_BITS];
	assign slot_rd = ram_rdata[SLOT_W-1:0];

	// shared compare unit: one magnitude compare per scanned entry
	assign seq_eq = (seq_rd == key_q);
	assign seq_ge = (seq_rd >= key_q);
	assign hit    = (func_q == FUNC_SERVE) ? slot_rd[SLOT_W-1] : seq_ge;

	assign put_seq = (func_q == FUNC_SERVE) ? seq_hit_q : key_q;

	// ram write: tail move or final placement
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			S_SH_WR: begin
				ram_we = 1'b1;
				if (func_q == FUNC_INSERT) begin
					ram_waddr = AW'(idx_q + 1'b1);
				end else begin
					ram_waddr = AW'(idx_q - 1'b1);
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = {put_seq, slot_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer with registered result and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			func_q       <= FUNC_INSERT;
			key_q        <= '0;
			slot_q       <= '0;
			idx_q        <= '0;
			pos_q        <= '0;
			count_q      <= '0;
			match_q      <= 1'b0;
			seq_hit_q    <= '0;
			slot_hit_q   <= '0;
			res_status_q <= ST_OK;
			res_seq_q    <= '0;
			res_slot_q   <= SLOT_NONE;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			out_seq_q    <= '0;
			out_slot_q   <= SLOT_NONE;
			count_now_q  <= '0;
		end else begin
			// output beat taken; a waiting result reloads it below
			if (out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func_t'(func);
						key_q   <= key_ext;
						slot_q  <= slot_value;
						idx_q   <= '0;
						state_q <= S_RD;
					end
				end
				// scan: stop at end of valid entries
				S_RD: begin
					if (idx_q == count_q) begin
						pos_q   <= count_q;
						match_q <= 1'b0;
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (hit) begin
						pos_q      <= idx_q;
						match_q    <= (func_q == FUNC_SERVE) || seq_eq;
						seq_hit_q  <= seq_rd;
						slot_hit_q <= slot_rd;
						state_q    <= S_DECIDE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DECIDE: begin
					case (func_q)
						FUNC_INSERT: begin
							res_seq_q  <= '0;
							res_slot_q <= SLOT_NONE;
							if (match_q) begin
								res_status_q <= ST_DUP;
								state_q      <= S_RESP;
							end else if (count_q == CW'(DEPTH)) begin
								res_status_q <= ST_FULL;
								state_q      <= S_RESP;
							end else if (pos_q == count_q) begin
								res_status_q <= ST_OK;
								state_q      <= S_PUT;
							end else begin
								res_status_q <= ST_OK;
								idx_q        <= count_q - 1'b1;
								state_q      <= S_SH_RD;
							end
						end
						FUNC_DELETE: begin
							res_slot_q <= SLOT_NONE;
							if (!match_q) begin
								res_status_q <= ST_NOT_FOUND;
								res_seq_q    <= '0;
								state_q      <= S_RESP;
							end else begin
								res_status_q <= ST_OK;
								res_seq_q    <= KEY_W'(key_q);
								if (pos_q + 1'b1 == count_q) begin
									count_q <= count_q - 1'b1;
									state_q <= S_RESP;
								end else begin
									idx_q   <= pos_q + 1'b1;
									state_q <= S_SH_RD;
								end
							end
						end
						FUNC_LOOKUP: begin
							if (!match_q) begin
								res_status_q <= ST_NOT_FOUND;
								res_seq_q    <= '0;
								res_slot_q   <= SLOT_NONE;
							end else begin
								res_status_q <= ST_OK;
								res_seq_q    <= KEY_W'(key_q);
								res_slot_q   <= slot_hit_q;
							end
							state_q <= S_RESP;
						end
						FUNC_SERVE: begin
							res_slot_q <= SLOT_NONE;
							if (!match_q) begin
								res_status_q <= ST_NOT_FOUND;
								res_seq_q    <= '0;
								state_q      <= S_RESP;
							end else begin
								res_status_q <= ST_OK;
								res_seq_q    <= KEY_W'(seq_hit_q);
								state_q      <= S_PUT;
							end
						end
						default: begin
							res_status_q <= ST_OK;
							res_seq_q    <= '0;
							res_slot_q   <= SLOT_NONE;
							state_q      <= S_RESP;
						end
					endcase
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				// tail move: up for insert, down for delete
				S_SH_WR: begin
					if (func_q == FUNC_INSERT) begin
						if (idx_q == pos_q) begin
							state_q <= S_PUT;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_SH_RD;
						end
					end else begin
						if (idx_q + 1'b1 == count_q) begin
							count_q <= count_q - 1'b1;
							state_q <= S_RESP;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_SH_RD;
						end
					end
				end
				S_PUT: begin
					if (func_q == FUNC_INSERT) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				// hand result to output register once it is free
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						out_seq_q   <= res_seq_q;
						out_slot_q  <= res_slot_q;
						count_now_q <= COUNT_W'(count_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_seq   = out_seq_q;
	assign out_slot  = out_slot_q;
	assign count_now = count_now_q;

endmodule

`default_nettype wire

// ----- design/ssrt_checker.sv -----
`default_nettype none

module ssrt_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [ssrt_pkg::STAT_W-1:0] status,
	input wire logic [ssrt_pkg::KEY_W-1:0]  out_seq,
	input wire logic [ssrt_pkg::SLOT_W-1:0] out_slot,
	input wire logic [ssrt_pkg::COUNT_W-1:0] count_now
);

	import ssrt_pkg::*;

	// in_ready is low in the cycle after an accepted operation
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted beat");

	// a stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_seq)
			&& $stable(out_slot) && $stable(count_now))
		else $error("result beat changed while stalled");

	// failed operations report no sequence and no slot
	a_fail_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_seq == '0 && out_slot == SLOT_NONE)
		else $error("failed operation carries a sequence or slot");

	// entry count never exceeds the table size (checked only for DEPTH below 32)
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (DEPTH >= 32) || (count_now <= COUNT_W'(DEPTH)))
		else $error("entry count above table size");

endmodule

bind sorted_seq_reorder_table ssrt_checker #(
	.DEPTH(DEPTH)
) u_ssrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.out_seq   (out_seq),
	.out_slot  (out_slot),
	.count_now (count_now)
);

`default_nettype wire

// ----- bench/sorted_seq_reorder_table_tb.sv -----
`default_nettype none

module sorted_seq_reorder_table_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import ssrt_pkg::*;

	localparam int TBL_DEPTH   = 16;
	localparam int SEQ_W       = 32;
	localparam int POOL_SIZE   = 24;
	localparam int IDLE_PCT    = 21;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_WAIT  = 100;

	typedef struct packed {
		func_t              func;
		logic [KEY_W-1:0]   key;
		logic [SLOT_W-1:0]  slot;
	} op_beat_t;

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   seq;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [FUNC_W-1:0]    func = '0;
	logic [KEY_W-1:0]     key_seq = '0;
	logic [SLOT_W-1:0]    slot_value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [STAT_W-1:0]    status;
	logic [KEY_W-1:0]     out_seq;
	logic [SLOT_W-1:0]    out_slot;
	logic [COUNT_W-1:0]   count_now;

	// predicted table contents
	logic [KEY_W-1:0]  tbl_seq [TBL_DEPTH];
	logic [SLOT_W-1:0] tbl_slot [TBL_DEPTH];
	int                tbl_count = 0;

	op_beat_t      pending_ops [$];
	table_result_t results_due [$];
	op_beat_t      cur_op;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int  n_accepted = 0;
	int  err_count = 0;
	logic hold_off = 1'b0;
	logic steady;

	sorted_seq_reorder_table #(
		.DEPTH(TBL_DEPTH),
		.SEQ_BITS(SEQ_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.key_seq(key_seq),
		.slot_value(slot_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_seq(out_seq),
		.out_slot(out_slot),
		.count_now(count_now)
	);

	// clock
	always #6 clk = ~clk;

	// stretch with no idling on either side
	assign steady = (n_accepted >= 600) && (n_accepted < 750);

	// apply one operation to the predicted table, return its result beat
	function automatic table_result_t reorder_apply(op_beat_t op);
		table_result_t r;
		int hit;
		int p;
		r.status = ST_OK;
		r.seq = '0;
		r.slot = SLOT_NONE;
		hit = -1;
		for (int i = 0; i < tbl_count; i++) begin
			if (hit < 0 && tbl_seq[i] == op.key)
				hit = i;
		end
		case (op.func)
			FUNC_INSERT: begin
				if (hit >= 0) begin
					r.status = ST_DUP;
				end else if (tbl_count >= TBL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					p = 0;
					while (p < tbl_count && tbl_seq[p] < op.key)
						p++;
					for (int q = tbl_count; q > p; q--) begin
						tbl_seq[q] = tbl_seq[q-1];
						tbl_slot[q] = tbl_slot[q-1];
					end
					tbl_seq[p] = op.key;
					tbl_slot[p] = op.slot;
					tbl_count++;
				end
			end
			FUNC_DELETE: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.seq = op.key;
					for (int q = hit; q + 1 < tbl_count; q++) begin
						tbl_seq[q] = tbl_seq[q+1];
						tbl_slot[q] = tbl_slot[q+1];
					end
					tbl_count--;
				end
			end
			FUNC_LOOKUP: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.seq = op.key;
					r.slot = tbl_slot[hit];
				end
			end
			default: begin
				// first entry whose slot has the sign bit set
				p = 0;
				while (p < tbl_count && !tbl_slot[p][SLOT_W-1])
					p++;
				if (p >= tbl_count) begin
					r.status = ST_NOT_FOUND;
				end else begin
					tbl_slot[p] = op.slot;
					r.seq = tbl_seq[p];
				end
			end
		endcase
		r.count = COUNT_W'(tbl_count);
		return r;
	endfunction

	task automatic push_op(input func_t f, input logic [KEY_W-1:0] k,
			input logic [SLOT_W-1:0] s);
		op_beat_t op;
		op.func = f;
		op.key = k;
		op.slot = s;
		pending_ops.push_back(op);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(99) < 15)
			return $urandom;
		return key_pool[$urandom_range(POOL_SIZE-1)];
	endfunction

	function automatic logic [SLOT_W-1:0] pick_slot(input int none_pct);
		if ($urandom_range(99) < none_pct)
			return SLOT_NONE;
		return SLOT_W'($urandom_range(255));
	endfunction

	// input side: predict on each accepted beat, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				results_due.push_back(reorder_apply(cur_op));
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_ops.size() != 0 &&
						(steady || $urandom_range(99) >= IDLE_PCT)) begin
					cur_op = pending_ops.pop_front();
					in_valid <= 1'b1;
					func <= cur_op.func;
					key_seq <= cur_op.key;
					slot_value <= cur_op.slot;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side ready, with random stalls and the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_off && (steady || $urandom_range(99) >= IDLE_PCT);
	end

	// hold the receiver off long enough for the block to back up
	initial begin
		while (n_accepted < 300)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		table_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing expected");
				err_count++;
			end else begin
				exp_r = results_due.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					err_count++;
				end
				if (out_seq !== exp_r.seq) begin
					$error("out_seq: expected %h, got %h", exp_r.seq, out_seq);
					err_count++;
				end
				if (out_slot !== exp_r.slot) begin
					$error("out_slot: expected %h, got %h", exp_r.slot, out_slot);
					err_count++;
				end
				if (count_now !== exp_r.count) begin
					$error("count_now: expected %0d, got %0d", exp_r.count, count_now);
					err_count++;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int roll;
		int ins_pct;
		int del_pct;
		int lkp_pct;
		logic [KEY_W-1:0] base;

		// empty table: misses and nothing to serve
		push_op(FUNC_LOOKUP, 32'd5, SLOT_NONE);
		push_op(FUNC_DELETE, 32'd5, 9'd0);
		push_op(FUNC_SERVE, 32'd0, 9'd1);
		// key and slot extremes, duplicate, out-of-order inserts
		push_op(FUNC_INSERT, 32'h0000_0000, SLOT_NONE);
		push_op(FUNC_INSERT, 32'hFFFF_FFFF, 9'd255);
		push_op(FUNC_INSERT, 32'h0000_0000, 9'd4);
		push_op(FUNC_INSERT, 32'd100, 9'd0);
		push_op(FUNC_INSERT, 32'd50, SLOT_NONE);
		// serve in order; a negative slot leaves the entry unassigned
		push_op(FUNC_SERVE, 32'd0, 9'd7);
		push_op(FUNC_SERVE, 32'hFFFF_FFFF, SLOT_NONE);
		push_op(FUNC_SERVE, 32'd0, 9'd3);
		push_op(FUNC_SERVE, 32'd0, 9'd9);
		push_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 9'd0);
		// fill up from the middle, then full and duplicate-on-full
		for (int i = 0; i < 12; i++)
			push_op(FUNC_INSERT, 32'(90 - 7 * i), pick_slot(50));
		push_op(FUNC_INSERT, 32'd7, 9'd1);
		push_op(FUNC_INSERT, 32'd50, 9'd1);
		push_op(FUNC_DELETE, 32'hFFFF_FFFF, 9'd0);

		// random phases: fill, mixed, drain, with a new key pool at each fill
		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 3 == 0) begin
				base = (ph == 3) ? 32'hFFFF_FFD0 : ((ph == 6) ? 32'd0 : $urandom);
				foreach (key_pool[i])
					key_pool[i] = base + 32'($urandom_range(60));
			end
			case (ph % 3)
				0: begin ins_pct = 60; del_pct = 10; lkp_pct = 15; end
				1: begin ins_pct = 25; del_pct = 25; lkp_pct = 25; end
				default: begin ins_pct = 15; del_pct = 55; lkp_pct = 15; end
			endcase
			for (int n = 0; n < 100; n++) begin
				roll = $urandom_range(99);
				if (roll < ins_pct)
					push_op(FUNC_INSERT, pick_key(), pick_slot(50));
				else if (roll < ins_pct + del_pct)
					push_op(FUNC_DELETE, pick_key(), pick_slot(20));
				else if (roll < ins_pct + del_pct + lkp_pct)
					push_op(FUNC_LOOKUP, pick_key(), pick_slot(20));
				else
					push_op(FUNC_SERVE, pick_key(), pick_slot(20));
			end
		end

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every beat to go in and every result to come back
		while (pending_ops.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d results never arrived", results_due.size());
			err_count++;
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#9_600_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
